>>> rtl/core/segment_tree_range_sum_assert.svh
// Assertion macros shared by the segment tree range-sum modules.
`ifndef SEGMENT_TREE_RANGE_SUM_ASSERT_SVH
`define SEGMENT_TREE_RANGE_SUM_ASSERT_SVH

// Checked only while out of reset.
`define STSUM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define STSUM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/stsum_pkg.sv
// Types and constants of the segment tree range-sum block.
package stsum_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned SIZE_W = 11;

  localparam logic [SIZE_W-1:0] SIZE_RST = 11'd1024;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic upd_read;
    logic upd_write;
    logic qry_read;
    logic qry_acc;
    logic out_load;
  } stsum_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic is_query;
    logic upd_ok;
    logic qry_bad;
    logic at_root;
    logic qry_done;
    logic out_free;
  } stsum_sts_t;

endpackage

>>> rtl/core/stsum_if.sv
// Valid/ready channel interfaces for items and results.
interface stsum_in_if import stsum_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [IDX_W-1:0]         elem_index;
  logic signed [DATA_W-1:0] elem_value;
  logic [IDX_W-1:0]         range_low;
  logic [IDX_W-1:0]         range_high;

  modport source (
    output valid, cmd, elem_index, elem_value, range_low, range_high,
    input  ready
  );
  modport sink (
    input  valid, cmd, elem_index, elem_value, range_low, range_high,
    output ready
  );
endinterface

interface stsum_out_if import stsum_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] range_sum;
  logic                     range_error;

  modport source (
    output valid, range_sum, range_error,
    input  ready
  );
  modport sink (
    input  valid, range_sum, range_error,
    output ready
  );
endinterface

>>> rtl/core/stsum_ctrl.sv
// Sequencer for clearing, update walks and query walks of the tree.
`include "segment_tree_range_sum_assert.svh"

module stsum_ctrl import stsum_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  stsum_sts_t sts_i,
  output stsum_cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_UPD_RD  = 3'd2;
  localparam logic [2:0] S_UPD_WR  = 3'd3;
  localparam logic [2:0] S_QRY_RD  = 3'd4;
  localparam logic [2:0] S_QRY_ACC = 3'd5;
  localparam logic [2:0] S_OUT     = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.is_query) begin
            state_d = sts_i.qry_bad ? S_OUT : S_QRY_RD;
          end else if (sts_i.upd_ok) begin
            state_d = S_UPD_RD;
          end
        end
      end
      S_UPD_RD: begin
        if (sts_i.at_root) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.upd_read = 1'b1;
          state_d        = S_UPD_WR;
        end
      end
      S_UPD_WR: begin
        cmd_o.upd_write = 1'b1;
        state_d         = S_UPD_RD;
      end
      S_QRY_RD: begin
        if (sts_i.qry_done) begin
          state_d = S_OUT;
        end else begin
          cmd_o.qry_read = 1'b1;
          state_d        = S_QRY_ACC;
        end
      end
      S_QRY_ACC: begin
        cmd_o.qry_acc = 1'b1;
        state_d       = S_QRY_RD;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `STSUM_ASSERT(a_no_write_above_root, cmd_o.upd_write |-> !sts_i.at_root, "update walked past root")
  `STSUM_ASSERT(a_load_into_free_slot, cmd_o.out_load |-> sts_i.out_free, "result would be lost")
  `STSUM_ASSERT_ALWAYS(a_clear_before_accept, !rst_ni |=> !in_ready_o, "ready before clearing")

endmodule

>>> rtl/core/stsum_datapath.sv
// Tree memory, walk registers, config register and result register.
`include "segment_tree_range_sum_assert.svh"

module stsum_datapath import stsum_pkg::*; #(
  parameter int unsigned MAX_ELEMS = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [SIZE_W-1:0]        cfg_data_i,
  input  stsum_cmd_t               cmd_i,
  output stsum_sts_t               sts_o,
  input  logic                     in_cmd_i,
  input  logic [IDX_W-1:0]         in_elem_index_i,
  input  logic signed [DATA_W-1:0] in_elem_value_i,
  input  logic [IDX_W-1:0]         in_range_low_i,
  input  logic [IDX_W-1:0]         in_range_high_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [DATA_W-1:0] out_range_sum_o,
  output logic                     out_range_error_o
);

  localparam int unsigned NODES = 2 * MAX_ELEMS;
  localparam int unsigned NW    = $clog2(NODES);
  localparam int unsigned PW    = NW + 1;
  localparam int unsigned CW    = (PW > SIZE_W) ? PW : SIZE_W;

  logic [DATA_W-1:0] mem_q [NODES];
  logic [DATA_W-1:0] rd_a_q, rd_b_q;

  logic [SIZE_W-1:0] active_size_q;
  logic [NW-1:0]     clr_cnt_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_sum_q;
  logic              out_err_q;

  // node_q is the path node on update and the left bound on query
  logic [PW-1:0]     node_q, r_q;
  logic [DATA_W-1:0] acc_q, val_q;
  logic              err_q, odd_l_q, odd_r_q;

  logic [CW-1:0] max_ext, act_ext, eff_size, idx_ext, lo_ext, hi_ext;
  logic [PW-1:0] leaf, qry_l, qry_r, parent, sib, r_dec, l_step, r_step;
  logic [DATA_W-1:0] upd_sum, acc_sum;
  logic          upd_ok, qry_bad, is_query, out_free;

  logic              wr_en;
  logic [NW-1:0]     wr_addr, rd_a_addr, rd_b_addr;
  logic [DATA_W-1:0] wr_data;

  assign max_ext  = CW'(MAX_ELEMS);
  assign act_ext  = CW'(active_size_q);
  assign eff_size = (act_ext > max_ext) ? max_ext : act_ext;
  assign idx_ext  = CW'(in_elem_index_i);
  assign lo_ext   = CW'(in_range_low_i);
  assign hi_ext   = CW'(in_range_high_i);

  assign is_query = (in_cmd_i == CMD_QUERY);
  assign upd_ok   = (idx_ext < eff_size);
  assign qry_bad  = (lo_ext > hi_ext) || (hi_ext >= eff_size);

  assign leaf   = PW'(max_ext + idx_ext);
  assign qry_l  = PW'(max_ext + lo_ext);
  assign qry_r  = PW'(max_ext + hi_ext + CW'(1));
  assign parent = node_q >> 1;
  assign sib    = node_q ^ PW'(1);
  assign r_dec  = r_q - PW'(1);
  assign l_step = node_q + PW'(odd_l_q);
  assign r_step = r_q - PW'(odd_r_q);

  assign upd_sum = val_q + rd_a_q;
  assign acc_sum = acc_q + (odd_l_q ? rd_a_q : '0) + (odd_r_q ? rd_b_q : '0);

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd_i.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
    end else if (cmd_i.accept && !is_query && upd_ok) begin
      wr_en   = 1'b1;
      wr_addr = leaf[NW-1:0];
      wr_data = $unsigned(in_elem_value_i);
    end else if (cmd_i.upd_write) begin
      wr_en   = 1'b1;
      wr_addr = parent[NW-1:0];
      wr_data = upd_sum;
    end
  end

  assign rd_a_addr = cmd_i.upd_read ? sib[NW-1:0] : node_q[NW-1:0];
  assign rd_b_addr = r_dec[NW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_a_q <= mem_q[rd_a_addr];
    rd_b_q <= mem_q[rd_b_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (is_query) begin
        node_q <= qry_l;
        r_q    <= qry_r;
        acc_q  <= '0;
        err_q  <= qry_bad;
      end else begin
        node_q <= leaf;
        val_q  <= $unsigned(in_elem_value_i);
      end
    end
    if (cmd_i.qry_read) begin
      odd_l_q <= node_q[0];
      odd_r_q <= r_q[0];
    end
    if (cmd_i.qry_acc) begin
      acc_q  <= acc_sum;
      node_q <= l_step >> 1;
      r_q    <= r_step >> 1;
    end
    if (cmd_i.upd_write) begin
      node_q <= parent;
      val_q  <= upd_sum;
    end
    if (cmd_i.out_load) begin
      out_sum_q <= acc_q;
      out_err_q <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_size_q <= SIZE_RST;
      clr_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) active_size_q <= cfg_data_i;
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + NW'(1);
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_done = (clr_cnt_q == NW'(NODES - 1));
  assign sts_o.is_query = is_query;
  assign sts_o.upd_ok   = upd_ok;
  assign sts_o.qry_bad  = qry_bad;
  assign sts_o.at_root  = (node_q <= PW'(1));
  assign sts_o.qry_done = !(node_q < r_q);
  assign sts_o.out_free = out_free;

  assign out_valid_o       = out_valid_q;
  assign out_range_sum_o   = signed'(out_sum_q);
  assign out_range_error_o = out_err_q;

  `STSUM_ASSERT(a_node_zero_untouched, (wr_en && !cmd_i.clr_step) |-> (wr_addr != '0), "write to node 0")
  `STSUM_ASSERT(a_bounds_ordered, cmd_i.qry_acc |=> (node_q <= r_q), "query bounds crossed")
  `STSUM_ASSERT(a_read_in_range, cmd_i.qry_read |-> (node_q < r_q), "query read past bounds")

endmodule

>>> rtl/core/segment_tree_range_sum.sv
// Range-sum segment tree with point update, one item in flight.
// Update: each tree level takes a sibling read, then a parent write.
// Query: two reads per level on a two-port memory, then an accumulate step.
// A bad range skips the walk and goes straight to the result register.
// After reset a clearing pass zeroes the tree, items held off.
// The result register lets the next item enter while a result waits.
module segment_tree_range_sum import stsum_pkg::*; #(
  parameter int unsigned MAX_ELEMS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  stsum_in_if.sink          in_i,
  stsum_out_if.source       out_o
);

  stsum_cmd_t cmd;
  stsum_sts_t sts;
  logic       in_ready;

  assign in_i.ready = in_ready;

  stsum_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stsum_datapath #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_cmd_i          (in_i.cmd),
    .in_elem_index_i   (in_i.elem_index),
    .in_elem_value_i   (in_i.elem_value),
    .in_range_low_i    (in_i.range_low),
    .in_range_high_i   (in_i.range_high),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_range_sum_o   (out_o.range_sum),
    .out_range_error_o (out_o.range_error)
  );

endmodule

>>> sim/testbench.sv
// Testbench for segment_tree_range_sum: random and directed updates and queries vs a flat model.
module testbench;
  import stsum_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ELEMS     = 1024;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STALL_LIMIT   = 10000;

  typedef struct {
    logic                     cmd;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] val;
    logic [IDX_W-1:0]         lo;
    logic [IDX_W-1:0]         hi;
  } tree_op_t;

  typedef struct {
    logic signed [DATA_W-1:0] sum;
    logic                     err;
  } range_result_t;

  // Keeps the element array flat; a wrapped sum does not depend on tree shape.
  class range_sum_tracker;
    logic [DATA_W-1:0] elems [MAX_ELEMS];
    int unsigned       span;
    range_result_t     expected_sums[$];
    int unsigned       errors, updates, skipped_updates, queries, bad_queries, checked;

    function new();
      foreach (elems[i]) elems[i] = '0;
      span = MAX_ELEMS;
    endfunction

    function void set_size(logic [SIZE_W-1:0] v);
      span = (32'(v) > MAX_ELEMS) ? MAX_ELEMS : 32'(v);
    endfunction

    function void take_item(tree_op_t op);
      range_result_t     res;
      logic [DATA_W-1:0] acc;
      if (op.cmd == CMD_UPDATE) begin
        updates++;
        if (op.idx < span) elems[op.idx] = op.val;
        else skipped_updates++;
      end else begin
        queries++;
        if (op.lo > op.hi || op.hi >= span) begin
          bad_queries++;
          res.sum = '0;
          res.err = 1'b1;
        end else begin
          acc = '0;
          for (int unsigned i = op.lo; i <= op.hi; i++) acc += elems[i];
          res.sum = acc;
          res.err = 1'b0;
        end
        expected_sums.push_back(res);
      end
    endfunction

    function void check_sum(logic signed [DATA_W-1:0] sum, logic err);
      range_result_t exp_res;
      if (expected_sums.size() == 0) begin
        $error("unexpected result: range_sum=%0d range_error=%0b", sum, err);
        errors++;
        return;
      end
      exp_res = expected_sums.pop_front();
      checked++;
      if (sum !== exp_res.sum) begin
        $error("range_sum mismatch: expected %0d, got %0d", exp_res.sum, sum);
        errors++;
      end
      if (err !== exp_res.err) begin
        $error("range_error mismatch: expected %0b, got %0b", exp_res.err, err);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [SIZE_W-1:0] cfg_data_i;
  bit                idle_on = 1'b1;
  int unsigned       size_settings;
  int unsigned       quiet_cycles;
  int unsigned       out_hold;

  range_sum_tracker tracker = new();

  stsum_in_if  item_ch ();
  stsum_out_if sum_ch ();

  segment_tree_range_sum #(.MAX_ELEMS(MAX_ELEMS)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (item_ch),
    .out_o      (sum_ch)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: cycles without any transfer on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((item_ch.valid && item_ch.ready) || (sum_ch.valid && sum_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", quiet_cycles);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Result sink with random stall bursts.
  initial begin
    sum_ch.ready = 1'b0;
    out_hold     = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && sum_ch.valid && sum_ch.ready)
        tracker.check_sum(sum_ch.range_sum, sum_ch.range_error);
      if (out_hold != 0) begin
        out_hold--;
        sum_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_hold = $urandom_range(0, 12);
        sum_ch.ready <= 1'b0;
      end else begin
        sum_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic tree_op_t make_op(logic cmd, int unsigned idx, logic signed [DATA_W-1:0] val,
                                       int unsigned lo, int unsigned hi);
    tree_op_t op;
    op.cmd = cmd;
    op.idx = IDX_W'(idx);
    op.val = val;
    op.lo  = IDX_W'(lo);
    op.hi  = IDX_W'(hi);
    return op;
  endfunction

  // Mostly in-bounds updates and valid ranges; the rest is noise.
  function automatic tree_op_t rand_op(int unsigned span);
    tree_op_t    op;
    int unsigned reach;
    op.cmd = 1'($urandom_range(0, 1));
    op.idx = IDX_W'($urandom);
    op.val = pick_value();
    op.lo  = IDX_W'($urandom);
    op.hi  = IDX_W'($urandom);
    if (op.cmd == CMD_UPDATE) begin
      if (span != 0 && $urandom_range(0, 9) != 0) op.idx = IDX_W'($urandom_range(0, span - 1));
    end else if (span != 0 && $urandom_range(0, 7) != 0) begin
      op.hi = IDX_W'($urandom_range(0, span - 1));
      reach = (op.hi < 8) ? 32'(op.hi) : 8;
      if ($urandom_range(0, 1)) op.lo = IDX_W'($urandom_range(0, 32'(op.hi)));
      else op.lo = IDX_W'(32'(op.hi) - $urandom_range(0, reach));
    end
    return op;
  endfunction

  // Called at a rising edge; returns at the edge where the item transfers, or after a random idle gap.
  task automatic send_op(tree_op_t op);
    int unsigned gap;
    item_ch.valid      <= 1'b1;
    item_ch.cmd        <= op.cmd;
    item_ch.elem_index <= op.idx;
    item_ch.elem_value <= op.val;
    item_ch.range_low  <= op.lo;
    item_ch.range_high <= op.hi;
    do @(posedge clk_i); while (!item_ch.ready);
    tracker.take_item(op);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Updates give no result, so wait out a possible trailing update too.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (tracker.expected_sums.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_active_size(logic [SIZE_W-1:0] v);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_size(v);
    size_settings++;
  endtask

  task automatic run_phase(logic [SIZE_W-1:0] size, int unsigned count, bit with_idle);
    set_active_size(size);
    idle_on = with_idle;
    repeat (count) send_op(rand_op(tracker.span));
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_data_i         = '0;
    item_ch.valid      = 1'b0;
    item_ch.cmd        = CMD_UPDATE;
    item_ch.elem_index = '0;
    item_ch.elem_value = '0;
    item_ch.range_low  = '0;
    item_ch.range_high = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: all-zero start, extreme values, wraparound, bad ranges.
    send_op(make_op(CMD_QUERY, 0, 0, 0, 1023));
    send_op(make_op(CMD_UPDATE, 0, 32'sh7FFF_FFFF, 0, 0));
    send_op(make_op(CMD_UPDATE, 1023, 32'sh8000_0000, 1023, 1023));
    send_op(make_op(CMD_UPDATE, 512, -32'sd1, 0, 0));
    send_op(make_op(CMD_UPDATE, 1, 32'sd1, 1023, 0));
    send_op(make_op(CMD_QUERY, 1023, 32'sh7FFF_FFFF, 0, 1023));
    send_op(make_op(CMD_QUERY, 0, 0, 0, 1));
    send_op(make_op(CMD_QUERY, 0, 0, 1023, 1023));
    send_op(make_op(CMD_QUERY, 0, 0, 512, 512));
    send_op(make_op(CMD_QUERY, 0, 0, 5, 4));
    send_op(make_op(CMD_QUERY, 1023, -32'sd1, 1023, 0));
    send_op(make_op(CMD_QUERY, 0, 0, 0, 0));

    // Size 1: only element 0 is reachable.
    set_active_size(11'd1);
    send_op(make_op(CMD_QUERY, 0, 0, 0, 0));
    send_op(make_op(CMD_QUERY, 0, 0, 0, 1));
    send_op(make_op(CMD_UPDATE, 1, 32'sd77, 0, 0));
    send_op(make_op(CMD_QUERY, 0, 0, 1, 1));

    // Size 0: every query fails, every update is dropped.
    set_active_size(11'd0);
    send_op(make_op(CMD_QUERY, 0, 0, 0, 0));
    send_op(make_op(CMD_UPDATE, 0, 32'sd5, 0, 0));

    // Above the maximum: clamps to the full array, stored values survive.
    set_active_size(11'd2047);
    send_op(make_op(CMD_QUERY, 0, 0, 0, 1023));
    send_op(make_op(CMD_UPDATE, 1023, 32'sd3, 0, 0));
    send_op(make_op(CMD_QUERY, 0, 0, 1, 1023));

    run_phase(11'd1024, 200, 1'b1);
    run_phase(11'd2047, 150, 1'b1);
    run_phase(SIZE_W'($urandom_range(1, 1024)), 150, 1'b1);
    run_phase(SIZE_W'($urandom_range(2, 16)), 150, 1'b1);
    run_phase(11'd1, 60, 1'b1);
    run_phase(11'd512, 150, 1'b1);
    run_phase(SIZE_W'($urandom_range(1, 1024)), 150, 1'b1);
    run_phase(11'd1024, 250, 1'b0);

    wait_idle();
    $display("covered %0d updates (%0d outside the active size) and %0d queries (%0d bad ranges)",
             tracker.updates, tracker.skipped_updates, tracker.queries, tracker.bad_queries);
    $display("checked %0d results over %0d active-size settings",
             tracker.checked, size_settings);
    if (tracker.errors == 0 && tracker.expected_sums.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
